>>> sv/bsc_pkg.sv
// ----------------------------------------------------------------------------
// bsc_pkg
// Sizes, codes and state encoding shared by the safety check block.
// ----------------------------------------------------------------------------
package bsc_pkg;

    localparam int NUM_PROCS = 8;
    localparam int NUM_RES   = 4;

    // fixed field widths
    localparam int VAL_W   = 8;
    localparam int ORDER_W = 3;
    localparam int WORK_W  = 12;
    localparam logic [WORK_W-1:0] WORK_MAX = {WORK_W{1'b1}};

    // derived sizes
    localparam int PROC_W    = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
    localparam int RES_W     = (NUM_RES > 1) ? $clog2(NUM_RES) : 1;
    localparam int CNT_W     = $clog2(NUM_PROCS + 1);
    localparam int MEM_DEPTH = NUM_PROCS * NUM_RES;
    localparam int MEM_AW    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    // func codes
    localparam logic [1:0] FUNC_LOAD_AVAIL = 2'd0;
    localparam logic [1:0] FUNC_LOAD_PROC  = 2'd1;
    localparam logic [1:0] FUNC_RUN        = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_CHECK,
        ST_RELEASE,
        ST_EMIT,
        ST_UNSAFE
    } state_t;

endpackage

>>> sv/bsc_ram.sv
// ----------------------------------------------------------------------------
// bsc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                         clk,
    input  logic                                         we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                             wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                             rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/bankers_safety_check.sv
// ----------------------------------------------------------------------------
// bankers_safety_check
// Banker's algorithm safety check over stored max/allocation tables.
// ----------------------------------------------------------------------------
//  channel | handshake                     | payload
//  in      | in_valid, in_stall (driven)   | func, proc_index, res_index,
//          |                               | avail_value, max_value, alloc_value
//  out     | out_valid (driven), out_stall | safe, proc_in_order, last
//
//  A run copies the available counts to work, then checks each unfinished
//  process and, if it fits, releases its allocation into work, one resource
//  at a time through the single read port of the max/alloc RAM; at most
//  NUM_PROCS passes. Results leave one per cycle from an output register
//  while out_stall is low. Reset clears control state, work, marks and
//  sequence; RAMs hold garbage until loaded. in_stall is high during a run.
// ----------------------------------------------------------------------------
module bankers_safety_check
    import bsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [2:0]         proc_index,
    input  logic [1:0]         res_index,
    input  logic [VAL_W-1:0]   avail_value,
    input  logic [VAL_W-1:0]   max_value,
    input  logic [VAL_W-1:0]   alloc_value,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               safe,
    output logic [ORDER_W-1:0] proc_in_order,
    output logic               last
);

    state_t              state_reg, state_next;
    logic                ph_reg, ph_next;
    logic [PROC_W-1:0]   p_reg, p_next;
    logic [RES_W-1:0]    r_reg, r_next;
    logic [PROC_W-1:0]   k_reg, k_next;
    logic                any_reg, any_next;
    logic [CNT_W-1:0]    found_reg, found_next;
    logic                fin_reg [NUM_PROCS];
    logic                fin_next [NUM_PROCS];
    logic [ORDER_W-1:0]  seq_reg [NUM_PROCS];
    logic [ORDER_W-1:0]  seq_next [NUM_PROCS];
    logic [WORK_W-1:0]   work_reg [NUM_RES];
    logic [WORK_W-1:0]   work_next [NUM_RES];

    logic                out_valid_reg, out_valid_next;
    logic                safe_reg, safe_next;
    logic [ORDER_W-1:0]  order_reg, order_next;
    logic                last_reg, last_next;

    logic                accept;
    logic                avail_we;
    logic                proc_we;
    logic [RES_W-1:0]    avail_waddr;
    logic [MEM_AW-1:0]   proc_waddr;
    logic [MEM_AW-1:0]   proc_raddr;
    logic [VAL_W-1:0]    avail_rdata;
    logic [2*VAL_W-1:0]  proc_rdata;
    logic [VAL_W-1:0]    max_rd;
    logic [VAL_W-1:0]    alloc_rd;
    logic [WORK_W:0]     sum;
    logic                slot_free;
    logic                adv;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != ST_IDLE);

    // load write ports; out-of-range indexes are dropped
    assign avail_we    = accept && (func == FUNC_LOAD_AVAIL) && (int'(res_index) < NUM_RES);
    assign proc_we     = accept && (func == FUNC_LOAD_PROC) && (int'(res_index) < NUM_RES)
                         && (int'(proc_index) < NUM_PROCS);
    assign avail_waddr = RES_W'(res_index);
    assign proc_waddr  = MEM_AW'(int'(proc_index) * NUM_RES + int'(res_index));
    assign proc_raddr  = MEM_AW'(int'(p_reg) * NUM_RES + int'(r_reg));

    bsc_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NUM_RES)
    ) u_avail_ram (
        .clk   (clk),
        .we    (avail_we),
        .waddr (avail_waddr),
        .wdata (avail_value),
        .raddr (r_reg),
        .rdata (avail_rdata)
    );

    // max in the upper half, allocation in the lower half
    bsc_ram #(
        .WIDTH (2 * VAL_W),
        .DEPTH (MEM_DEPTH)
    ) u_proc_ram (
        .clk   (clk),
        .we    (proc_we),
        .waddr (proc_waddr),
        .wdata ({max_value, alloc_value}),
        .raddr (proc_raddr),
        .rdata (proc_rdata)
    );

    assign max_rd    = proc_rdata[2*VAL_W-1:VAL_W];
    assign alloc_rd  = proc_rdata[VAL_W-1:0];
    assign sum       = {1'b0, work_reg[r_reg]} + {{(WORK_W+1-VAL_W){1'b0}}, alloc_rd};
    assign slot_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            ph_reg        <= 1'b0;
            p_reg         <= '0;
            r_reg         <= '0;
            k_reg         <= '0;
            any_reg       <= 1'b0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_PROCS; i++)
            begin
                fin_reg[i] <= 1'b0;
                seq_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_RES; i++)
            begin
                work_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ph_reg        <= ph_next;
            p_reg         <= p_next;
            r_reg         <= r_next;
            k_reg         <= k_next;
            any_reg       <= any_next;
            found_reg     <= found_next;
            out_valid_reg <= out_valid_next;
            fin_reg       <= fin_next;
            seq_reg       <= seq_next;
            work_reg      <= work_next;
        end
    end

    always_ff @(posedge clk)
    begin
        safe_reg  <= safe_next;
        order_reg <= order_next;
        last_reg  <= last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        ph_next        = ph_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        k_next         = k_reg;
        any_next       = any_reg;
        found_next     = found_reg;
        fin_next       = fin_reg;
        seq_next       = seq_reg;
        work_next      = work_reg;
        out_valid_next = out_valid_reg && out_stall;
        safe_next      = safe_reg;
        order_next     = order_reg;
        last_next      = last_reg;
        adv            = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (func == FUNC_RUN))
                begin
                    state_next = ST_INIT;
                    r_next     = '0;
                    ph_next    = 1'b0;
                end
            end

            ST_INIT:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    work_next[r_reg] = {{(WORK_W-VAL_W){1'b0}}, avail_rdata};
                    ph_next          = 1'b0;
                    if (int'(r_reg) == NUM_RES - 1)
                    begin
                        state_next = ST_CHECK;
                        p_next     = '0;
                        r_next     = '0;
                        any_next   = 1'b0;
                        found_next = '0;
                        for (int i = 0; i < NUM_PROCS; i++)
                        begin
                            fin_next[i] = 1'b0;
                            seq_next[i] = '0;
                        end
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end

            ST_CHECK:
            begin
                if (fin_reg[p_reg])
                begin
                    adv = 1'b1;
                end
                else if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next = 1'b0;
                    // negative need always fits
                    if ((max_rd > alloc_rd)
                        && ({{(WORK_W-VAL_W){1'b0}}, max_rd - alloc_rd} > work_reg[r_reg]))
                    begin
                        adv = 1'b1;
                    end
                    else if (int'(r_reg) == NUM_RES - 1)
                    begin
                        state_next = ST_RELEASE;
                        r_next     = '0;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end

            ST_RELEASE:
            begin
                if (!ph_reg)
                begin
                    ph_next = 1'b1;
                end
                else
                begin
                    ph_next          = 1'b0;
                    work_next[r_reg] = sum[WORK_W] ? WORK_MAX : sum[WORK_W-1:0];
                    if (int'(r_reg) == NUM_RES - 1)
                    begin
                        seq_next[found_reg[PROC_W-1:0]] = ORDER_W'(p_reg);
                        found_next                      = found_reg + 1'b1;
                        fin_next[p_reg]                 = 1'b1;
                        any_next                        = 1'b1;
                        adv                             = 1'b1;
                    end
                    else
                    begin
                        r_next = r_reg + 1'b1;
                    end
                end
            end

            ST_EMIT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    safe_next      = 1'b1;
                    order_next     = seq_reg[k_reg];
                    last_next      = (int'(k_reg) == NUM_PROCS - 1);
                    if (int'(k_reg) == NUM_PROCS - 1)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        k_next = k_reg + 1'b1;
                    end
                end
            end

            ST_UNSAFE:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    safe_next      = 1'b0;
                    order_next     = '0;
                    last_next      = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // move on to the next process or end the run; a pass ends at the highest index
        if (adv)
        begin
            r_next  = '0;
            ph_next = 1'b0;
            if (found_next == CNT_W'(NUM_PROCS))
            begin
                state_next = ST_EMIT;
                k_next     = '0;
            end
            else if (int'(p_reg) == NUM_PROCS - 1)
            begin
                if (!any_next)
                begin
                    state_next = ST_UNSAFE;
                end
                else
                begin
                    state_next = ST_CHECK;
                    p_next     = '0;
                    any_next   = 1'b0;
                end
            end
            else
            begin
                state_next = ST_CHECK;
                p_next     = p_reg + 1'b1;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign safe          = safe_reg;
    assign proc_in_order = order_reg;
    assign last          = last_reg;

    // assertions
    a_found_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(found_reg) <= NUM_PROCS)
        else $error("found count beyond process count");

    a_emit_all_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (found_reg == CNT_W'(NUM_PROCS)))
        else $error("sequence emitted before every process finished");

    a_unsafe_form: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !safe_reg) |-> (last_reg && (order_reg == '0)))
        else $error("unsafe transaction not a single last result");

    a_run_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (func == FUNC_RUN)) |=> (state_reg == ST_INIT))
        else $error("run transaction did not start the check");

endmodule

>>> tb/tb_bankers_safety_check.sv
// ----------------------------------------------------------------------------
// tb_bankers_safety_check
// Self-checking bench for the Banker's algorithm safety check block.
// Loads the available, max and allocation tables, issues runs, and predicts
// each run's safe sequence or unsafe verdict in an in-bench model. Every
// returned transaction is checked field by field against the oldest
// prediction. The input idles and the output stalls at random.
// ----------------------------------------------------------------------------
module tb_bankers_safety_check
    import bsc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // func code that the block ignores
    localparam logic [1:0] FUNC_SPARE = 2'd3;

    typedef struct {
        logic [1:0]       func;
        logic [2:0]       pidx;
        logic [1:0]       ridx;
        logic [VAL_W-1:0] av;
        logic [VAL_W-1:0] mx;
        logic [VAL_W-1:0] al;
        int               gap;
        bit               drain;
    } request_t;

    typedef struct {
        logic               safe;
        logic [ORDER_W-1:0] order;
        logic               last;
    } verdict_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic [1:0]         func = '0;
    logic [2:0]         proc_index = '0;
    logic [1:0]         res_index = '0;
    logic [VAL_W-1:0]   avail_value = '0;
    logic [VAL_W-1:0]   max_value = '0;
    logic [VAL_W-1:0]   alloc_value = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic               safe;
    logic [ORDER_W-1:0] proc_in_order;
    logic               last;

    bankers_safety_check dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .proc_index    (proc_index),
        .res_index     (res_index),
        .avail_value   (avail_value),
        .max_value     (max_value),
        .alloc_value   (alloc_value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .safe          (safe),
        .proc_in_order (proc_in_order),
        .last          (last)
    );

    // pending stimulus and predicted verdicts
    request_t pending[$];
    verdict_t verdicts[$];

    // bench copy of the block's tables
    logic [VAL_W-1:0] avail_tbl [NUM_RES];
    logic [VAL_W-1:0] max_tbl   [MEM_DEPTH];
    logic [VAL_W-1:0] alloc_tbl [MEM_DEPTH];

    int  errors = 0;
    int  n_in = 0;
    int  n_out = 0;
    int  n_safe_runs = 0;
    int  n_unsafe_runs = 0;
    int  n_stalled_in = 0;
    int  gen_items = 0;
    bit  calm_tx = 1'b0;
    int  tx_gap = 0;
    int  rx_wait = 0;
    logic in_fire = 1'b0;
    logic out_fire = 1'b0;
    logic rx_hold = 1'b0;

    initial begin
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one accepted transaction to the table copy and
    // queues the verdicts that a run produces.
    // ------------------------------------------------------------------
    task automatic apply_request(input request_t c);
        int  work [NUM_RES];
        logic [NUM_PROCS-1:0] done;
        logic [ORDER_W-1:0] order [NUM_PROCS];
        int  found;
        int  m;
        int  a;
        bit  progress;
        bit  fits;
        verdict_t v;
        case (c.func)
            FUNC_LOAD_AVAIL:
                if (c.ridx < NUM_RES)
                    avail_tbl[c.ridx] = c.av;
            FUNC_LOAD_PROC:
                if (c.pidx < NUM_PROCS && c.ridx < NUM_RES)
                begin
                    max_tbl[c.pidx * NUM_RES + c.ridx]   = c.mx;
                    alloc_tbl[c.pidx * NUM_RES + c.ridx] = c.al;
                end
            FUNC_RUN:
            begin
                for (int r = 0; r < NUM_RES; r++)
                    work[r] = int'(avail_tbl[r]);
                done = '0;
                found = 0;
                progress = 1'b1;
                while (found < NUM_PROCS && progress)
                begin
                    progress = 1'b0;
                    for (int p = 0; p < NUM_PROCS; p++)
                    begin
                        if (!done[p])
                        begin
                            fits = 1'b1;
                            // negative need always fits
                            for (int r = 0; r < NUM_RES; r++)
                            begin
                                m = int'(max_tbl[p * NUM_RES + r]);
                                a = int'(alloc_tbl[p * NUM_RES + r]);
                                if (m > a && (m - a) > work[r])
                                    fits = 1'b0;
                            end
                            if (fits)
                            begin
                                for (int r = 0; r < NUM_RES; r++)
                                begin
                                    work[r] += int'(alloc_tbl[p * NUM_RES + r]);
                                    if (work[r] > int'(WORK_MAX))
                                        work[r] = int'(WORK_MAX);
                                end
                                order[found] = p[ORDER_W-1:0];
                                found++;
                                done[p] = 1'b1;
                                progress = 1'b1;
                            end
                        end
                    end
                end
                if (found < NUM_PROCS)
                begin
                    v = '{safe: 1'b0, order: '0, last: 1'b1};
                    verdicts.push_back(v);
                end
                else
                begin
                    for (int k = 0; k < NUM_PROCS; k++)
                    begin
                        v = '{safe: 1'b1, order: order[k], last: (k == NUM_PROCS - 1)};
                        verdicts.push_back(v);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // Stimulus builders
    // ------------------------------------------------------------------
    function automatic void enqueue(input logic [1:0] f, input int p, input int r,
                                    input int av, input int mx, input int al);
        request_t c;
        c.func  = f;
        c.pidx  = 3'(p);
        c.ridx  = 2'(r);
        c.av    = VAL_W'(av);
        c.mx    = VAL_W'(mx);
        c.al    = VAL_W'(al);
        c.gap   = calm_tx ? 0 : $urandom_range(0, 16);
        c.drain = 1'b0;
        pending.push_back(c);
        if (f != FUNC_SPARE)
            gen_items++;
    endfunction

    function automatic void load_avail(input int r, input int v);
        enqueue(FUNC_LOAD_AVAIL, $urandom_range(0, 7), r, v,
                $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    function automatic void load_proc(input int p, input int r, input int m, input int a);
        enqueue(FUNC_LOAD_PROC, p, r, $urandom_range(0, 255), m, a);
    endfunction

    function automatic void start_run();
        enqueue(FUNC_RUN, $urandom_range(0, 7), $urandom_range(0, 3),
                $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    endfunction

    // sender stops here until every predicted verdict has come back
    function automatic void hold_for_drain();
        request_t c;
        c = '{func: FUNC_LOAD_AVAIL, pidx: '0, ridx: '0, av: '0, mx: '0, al: '0,
              gap: 0, drain: 1'b1};
        pending.push_back(c);
    endfunction

    function automatic int extreme_val();
        return ($urandom_range(0, 1) ? 255 : 0) ^ $urandom_range(0, 1);
    endfunction

    // profiles: 0 uniform, 1 modest needs, 2 starved, 3 extremes
    function automatic int draw_avail(input int profile);
        case (profile)
            1:       return $urandom_range(0, 50);
            2:       return $urandom_range(0, 20);
            3:       return extreme_val();
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic void draw_pair(input int profile, output int m, output int a);
        case (profile)
            1:
            begin
                a = $urandom_range(0, 60);
                m = a + $urandom_range(0, 50);
            end
            2:
            begin
                a = $urandom_range(0, 20);
                m = a + $urandom_range(0, 255);
            end
            3:
            begin
                a = extreme_val();
                m = extreme_val();
            end
            default:
            begin
                a = $urandom_range(0, 255);
                m = $urandom_range(0, 255);
            end
        endcase
        if (m > 255)
            m = 255;
    endfunction

    task automatic fill_tables(input int profile);
        int m;
        int a;
        for (int r = 0; r < NUM_RES; r++)
            load_avail(r, draw_avail(profile));
        for (int p = 0; p < NUM_PROCS; p++)
            for (int r = 0; r < NUM_RES; r++)
            begin
                draw_pair(profile, m, a);
                load_proc(p, r, m, a);
            end
    endtask

    // ------------------------------------------------------------------
    // Input driver: changes on the falling edge, holds while stalled
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        request_t c;
        logic next_valid;
        if (rst_n && !(in_valid && !in_fire))
        begin
            next_valid = 1'b0;
            if (tx_gap != 0)
                tx_gap = tx_gap - 1;
            else if (pending.size() != 0)
            begin
                if (pending[0].drain)
                begin
                    if (verdicts.size() == 0)
                        void'(pending.pop_front());
                end
                else
                begin
                    c = pending.pop_front();
                    func        <= c.func;
                    proc_index  <= c.pidx;
                    res_index   <= c.ridx;
                    avail_value <= c.av;
                    max_value   <= c.mx;
                    alloc_value <= c.al;
                    tx_gap      = c.gap;
                    next_valid  = 1'b1;
                end
            end
            in_valid <= next_valid;
        end
    end

    // ------------------------------------------------------------------
    // Output side stall: random wait per result plus the long hold-off
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                rx_wait = ((n_out / 40) % 3 == 1) ? 0 : $urandom_range(0, 16);
            else if (rx_wait != 0 && out_valid)
                rx_wait = rx_wait - 1;
            out_stall <= rx_hold || (rx_wait != 0);
        end
    end

    initial
    begin
        wait (n_in >= 80);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge clk);
        rx_hold <= 1'b0;
    end

    // ------------------------------------------------------------------
    // Monitor: samples both channels on the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        request_t c;
        verdict_t e;
        in_fire  <= rst_n && in_valid && !in_stall;
        out_fire <= rst_n && out_valid && !out_stall;
        if (rst_n)
        begin
            if (in_valid && in_stall && rx_hold)
                n_stalled_in++;
            if (in_valid && !in_stall)
            begin
                c = '{func: func, pidx: proc_index, ridx: res_index, av: avail_value,
                      mx: max_value, al: alloc_value, gap: 0, drain: 1'b0};
                apply_request(c);
                n_in++;
            end
            if (out_valid && !out_stall)
            begin
                n_out++;
                if (verdicts.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result safe=%0b proc=%0d last=%0b",
                             $realtime, safe, proc_in_order, last);
                end
                else
                begin
                    e = verdicts.pop_front();
                    if (safe !== e.safe || proc_in_order !== e.order || last !== e.last)
                    begin
                        errors++;
                        $display("%0t: mismatch expected safe=%0b proc=%0d last=%0b",
                                 $realtime, e.safe, e.order, e.last,
                                 ", got safe=%0b proc=%0d last=%0b",
                                 safe, proc_in_order, last);
                    end
                    if (e.last)
                    begin
                        if (e.safe)
                            n_safe_runs++;
                        else
                            n_unsafe_runs++;
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of test
    // ------------------------------------------------------------------
    initial
    begin
        int cur_profile;
        int m;
        int a;

        // every table entry gets written before the first run
        for (int r = 0; r < NUM_RES; r++)
            load_avail(r, 0);
        for (int p = 0; p < NUM_PROCS; p++)
            for (int r = 0; r < NUM_RES; r++)
                load_proc(p, r, (p == NUM_PROCS - 1) ? 255 : 0,
                          (p == NUM_PROCS - 1) ? 255 : 0);
        start_run();                            // zero need everywhere
        enqueue(FUNC_SPARE, 7, 3, 255, 255, 255);
        load_proc(3, 2, 255, 0);                // needs the last process's release
        start_run();
        load_proc(7, 2, 255, 0);                // nobody can release: unsafe
        start_run();
        load_avail(2, 255);
        start_run();
        load_proc(0, 1, 0, 255);                // negative need
        load_proc(1, 1, 255, 254);
        load_avail(1, 0);
        start_run();
        for (int r = 0; r < NUM_RES; r++)
        begin
            load_avail(r, 255);
            load_proc(5, r, 255, 0);
        end
        start_run();
        hold_for_drain();

        cur_profile = 0;
        while (gen_items < 400)
        begin
            calm_tx = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
            begin
                cur_profile = $urandom_range(0, 3);
                fill_tables(cur_profile);
            end
            else
                repeat ($urandom_range(0, 5))
                begin
                    if ($urandom_range(0, 3) == 0)
                        load_avail($urandom_range(0, NUM_RES - 1), draw_avail(cur_profile));
                    else
                    begin
                        draw_pair(cur_profile, m, a);
                        load_proc($urandom_range(0, NUM_PROCS - 1),
                                  $urandom_range(0, NUM_RES - 1), m, a);
                    end
                end
            if ($urandom_range(0, 9) == 0)
                enqueue(FUNC_SPARE, $urandom_range(0, 7), $urandom_range(0, 3),
                        $urandom_range(0, 255), $urandom_range(0, 255),
                        $urandom_range(0, 255));
            start_run();
            if ($urandom_range(0, 11) == 0)
                hold_for_drain();
        end

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending.size() != 0 || in_valid || verdicts.size() != 0)
            @(posedge clk);
        repeat (64) @(posedge clk);

        $display("Ran %0d input transactions and checked %0d results.", n_in, n_out);
        $display("Runs: %0d safe, %0d unsafe; %0d input cycles stalled under output hold-off.",
                 n_safe_runs, n_unsafe_runs, n_stalled_in);
        if (errors == 0 && verdicts.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timeout with %0d results still expected", verdicts.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

>>> sim.f
sv/bsc_pkg.sv
sv/bsc_ram.sv
sv/bankers_safety_check.sv
tb/tb_bankers_safety_check.sv
